>>> src/pgp_packet_header_parser_core_macros.svh
// Assertion macros shared by the packet header parser RTL.
`ifndef PGP_PACKET_HEADER_PARSER_CORE_MACROS_SVH
`define PGP_PACKET_HEADER_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PGP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PGP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> src/pgp_pkg.sv
// Package with the shared types, codes and tag table of the packet header parser.
`default_nettype none

package pgp_pkg;

    // Depth of the queue between the classifier and the parser.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Result status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_INVALID    = 2'd1;
    localparam logic [1:0] ST_UNEXPECTED = 2'd2;

    // Tags with special handling.
    localparam logic [5:0] TAG_COMPRESSED = 6'd8;
    localparam logic [5:0] TAG_PRIVATE_63 = 6'd63;

    // Parser phases.
    typedef enum logic [3:0] {
        S_TAG  = 4'b0001,
        S_LEN  = 4'b0010,
        S_BODY = 4'b0100,
        S_HALT = 4'b1000
    } t_state;

    // One classified image byte as it travels through the queue.
    typedef struct packed {
        logic [7:0] data;
        logic       restart;
        logic       lead;
        logic       new_fmt;
        logic [5:0] tag;
        logic [1:0] len_type;
        logic       lt192;
        logic       lt224;
        logic       is_ff;
    } t_byte_info;

    // One packet record.
    typedef struct packed {
        logic [5:0]  packet_type;
        logic [31:0] body_offset;
        logic [31:0] body_length;
        logic [31:0] total_length;
        logic [1:0]  status;
        logic        last_packet;
    } t_result;

    // Tags that may appear in a keyblock.
    function automatic logic tag_allowed(input logic [5:0] t);
        logic ok;
        unique case (t)
            6'd2, 6'd5, 6'd6, 6'd7, 6'd10, 6'd12,
            6'd13, 6'd14, 6'd16, 6'd17, 6'd61, 6'd63: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

>>> src/pgp_front.sv
// Front end: takes image bytes and classifies them for the parser queue.
`default_nettype none

module pgp_front (
    input  wire logic               i_valid,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_restart,
    input  wire logic               i_full,
    output logic                    o_stall,
    output logic                    o_push,
    output pgp_pkg::t_byte_info     o_info
);

    // The queue back-pressures the input channel only when it is full.
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // Decode the tag forms and the length byte ranges once, up front.
    always_comb begin
        o_info.data     = i_data_byte;
        o_info.restart  = i_restart;
        o_info.lead     = i_data_byte[7];
        o_info.new_fmt  = i_data_byte[6];
        o_info.tag      = i_data_byte[6] ? i_data_byte[5:0] : {2'b00, i_data_byte[5:2]};
        o_info.len_type = i_data_byte[1:0];
        o_info.lt192    = (i_data_byte < 8'd192);
        o_info.lt224    = (i_data_byte < 8'd224);
        o_info.is_ff    = (i_data_byte == 8'd255);
    end

endmodule

`default_nettype wire

>>> src/pgp_fifo.sv
// Short queue of classified bytes between the front end and the parser.
`include "pgp_packet_header_parser_core_macros.svh"
`default_nettype none

module pgp_fifo (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire pgp_pkg::t_byte_info i_info,
    input  wire logic                i_pop,
    output pgp_pkg::t_byte_info      o_info,
    output logic                     o_full,
    output logic                     o_empty
);

    pgp_pkg::t_byte_info r_mem [pgp_pkg::FIFO_DEPTH];
    logic [pgp_pkg::PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [pgp_pkg::PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [pgp_pkg::CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == pgp_pkg::CNT_W'(pgp_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_info  = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == pgp_pkg::PTR_W'(pgp_pkg::FIFO_DEPTH - 1)) ? '0
                     : r_wr_ptr + pgp_pkg::PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == pgp_pkg::PTR_W'(pgp_pkg::FIFO_DEPTH - 1)) ? '0
                     : r_rd_ptr + pgp_pkg::PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + pgp_pkg::CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - pgp_pkg::CNT_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_info;
        end
    end

    `PGP_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1,
                    r_count <= pgp_pkg::CNT_W'(pgp_pkg::FIFO_DEPTH))
    `PGP_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0)
    `PGP_ASSERT_IMP(a_push_not_full, i_clk, i_rst_n, i_push, !o_full)

endmodule

`default_nettype wire

>>> src/pgp_back.sv
// Back end: header state machine, packet records and the output register.
`include "pgp_packet_header_parser_core_macros.svh"
`default_nettype none

module pgp_back #(
    parameter int POS_BITS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [31:0]         i_cfg_wr_data,
    input  wire pgp_pkg::t_byte_info i_info,
    input  wire logic                i_empty,
    output logic                     o_pop,
    input  wire logic                i_stall,
    output logic                     o_valid,
    output pgp_pkg::t_result         o_result
);

    // Width wide enough for both the position and the image length.
    localparam int CW = (POS_BITS > 32) ? POS_BITS : 32;

    logic [31:0]         r_image_length;
    pgp_pkg::t_state     r_state, n_state, w_cur_state;
    logic [POS_BITS-1:0] r_pos, n_pos, w_cur_pos;
    logic [2:0]          r_hdr_start, n_hdr_start, w_cur_hdr_start;
    logic [31:0]         r_acc, n_acc, w_cur_acc;
    logic [2:0]          r_left, n_left, w_cur_left;
    logic [5:0]          r_tag, n_tag, w_cur_tag;
    logic                r_new_fmt, n_new_fmt, w_cur_new_fmt;
    logic [31:0]         r_body_left, n_body_left, w_cur_body_left;

    logic                r_out_valid, n_out_valid;
    pgp_pkg::t_result    r_out;

    logic [CW-1:0]       w_pos_ext;
    logic [CW-1:0]       w_il_ext;
    logic [CW-1:0]       w_remain;
    logic [CW-1:0]       w_off;
    logic                w_active;
    logic [2:0]          w_old_len;
    logic [31:0]         w_acc_sum;
    logic [2:0]          w_hdr_size;
    logic                w_fin;
    logic [31:0]         w_fin_len;
    logic                w_fail;
    logic [1:0]          w_fail_code;
    logic                w_ok;
    logic                w_res_valid;
    pgp_pkg::t_result    w_res;

    // Take a queue entry whenever the output slot is free or being emptied.
    assign o_pop = !i_empty && (!r_out_valid || !i_stall);

    // A restart byte sees the cleared state.
    always_comb begin
        if (i_info.restart) begin
            w_cur_state     = pgp_pkg::S_TAG;
            w_cur_pos       = '0;
            w_cur_hdr_start = '0;
            w_cur_acc       = '0;
            w_cur_left      = '0;
            w_cur_tag       = '0;
            w_cur_new_fmt   = 1'b0;
            w_cur_body_left = '0;
        end else begin
            w_cur_state     = r_state;
            w_cur_pos       = r_pos;
            w_cur_hdr_start = r_hdr_start;
            w_cur_acc       = r_acc;
            w_cur_left      = r_left;
            w_cur_tag       = r_tag;
            w_cur_new_fmt   = r_new_fmt;
            w_cur_body_left = r_body_left;
        end
    end

    // Offsets and the number of image bytes that follow this one.
    assign w_pos_ext  = CW'(w_cur_pos);
    assign w_il_ext   = CW'(r_image_length);
    assign w_remain   = w_il_ext - w_pos_ext - CW'(1);
    assign w_off      = w_pos_ext + CW'(1);
    assign w_active   = (w_cur_state != pgp_pkg::S_HALT) && (w_pos_ext < w_il_ext);
    assign w_old_len  = {i_info.len_type == 2'd2, i_info.len_type == 2'd1,
                         i_info.len_type == 2'd0};
    assign w_acc_sum  = w_cur_acc + 32'(i_info.data);
    assign w_hdr_size = w_cur_pos[2:0] + 3'd1 - w_cur_hdr_start;

    // Header state machine.
    always_comb begin
        n_state     = w_cur_state;
        n_pos       = w_cur_pos;
        n_hdr_start = w_cur_hdr_start;
        n_acc       = w_cur_acc;
        n_left      = w_cur_left;
        n_tag       = w_cur_tag;
        n_new_fmt   = w_cur_new_fmt;
        n_body_left = w_cur_body_left;
        w_fin       = 1'b0;
        w_fin_len   = '0;
        w_fail      = 1'b0;
        w_fail_code = pgp_pkg::ST_OK;
        w_ok        = 1'b0;

        if (w_active) begin
            n_pos = (w_cur_pos == '1) ? w_cur_pos : w_cur_pos + POS_BITS'(1);
            unique case (w_cur_state)
                pgp_pkg::S_TAG: begin
                    n_hdr_start = w_cur_pos[2:0];
                    n_acc       = '0;
                    n_tag       = '0;
                    if (!i_info.lead) begin
                        w_fail      = 1'b1;
                        w_fail_code = pgp_pkg::ST_INVALID;
                    end else if (i_info.new_fmt) begin
                        n_new_fmt = 1'b1;
                        n_tag     = i_info.tag;
                        n_left    = '0;
                        if (w_remain == '0) begin
                            w_fail      = 1'b1;
                            w_fail_code = pgp_pkg::ST_INVALID;
                        end else begin
                            n_state = pgp_pkg::S_LEN;
                        end
                    end else begin
                        n_new_fmt = 1'b0;
                        n_tag     = i_info.tag;
                        if (i_info.len_type == 2'd3) begin
                            w_fail      = 1'b1;
                            w_fail_code = pgp_pkg::ST_UNEXPECTED;
                        end else if (w_remain < CW'(w_old_len)) begin
                            w_fail      = 1'b1;
                            w_fail_code = pgp_pkg::ST_INVALID;
                        end else begin
                            n_left  = w_old_len;
                            n_state = pgp_pkg::S_LEN;
                        end
                    end
                end
                pgp_pkg::S_LEN: begin
                    if (w_cur_new_fmt && (w_cur_left == '0)) begin
                        // First length byte of a new-format header.
                        priority if (w_cur_tag == pgp_pkg::TAG_COMPRESSED) begin
                            w_fail      = 1'b1;
                            w_fail_code = pgp_pkg::ST_UNEXPECTED;
                        end else if (i_info.lt192) begin
                            w_fin     = 1'b1;
                            w_fin_len = 32'(i_info.data);
                        end else if (i_info.lt224) begin
                            if (w_remain == '0) begin
                                w_fail      = 1'b1;
                                w_fail_code = pgp_pkg::ST_INVALID;
                            end else begin
                                // (b - 192) * 256 + 192, with b in 192..223.
                                n_acc  = {19'd0, i_info.data[4:0], 8'hC0};
                                n_left = 3'd1;
                            end
                        end else if (i_info.is_ff) begin
                            if (w_remain < CW'(4)) begin
                                w_fail      = 1'b1;
                                w_fail_code = pgp_pkg::ST_INVALID;
                            end else begin
                                n_acc  = '0;
                                n_left = 3'd4;
                            end
                        end else begin
                            w_fail      = 1'b1;
                            w_fail_code = pgp_pkg::ST_UNEXPECTED;
                        end
                    end else if (w_cur_left > 3'd1) begin
                        // The accumulator stays shifted ahead of the next byte.
                        n_acc  = {w_acc_sum[23:0], 8'h00};
                        n_left = w_cur_left - 3'd1;
                    end else begin
                        w_fin     = 1'b1;
                        w_fin_len = w_acc_sum;
                    end
                end
                pgp_pkg::S_BODY: begin
                    if (w_cur_body_left > 32'd1) begin
                        n_body_left = w_cur_body_left - 32'd1;
                    end else begin
                        n_body_left = '0;
                        n_state     = pgp_pkg::S_TAG;
                    end
                end
                default: begin
                    n_state = w_cur_state;
                end
            endcase

            // The header is complete: check the packet against the image.
            if (w_fin) begin
                n_acc  = w_fin_len;
                n_left = '0;
                priority if (!pgp_pkg::tag_allowed(w_cur_tag)) begin
                    w_fail      = 1'b1;
                    w_fail_code = pgp_pkg::ST_UNEXPECTED;
                end else if ((w_cur_tag == pgp_pkg::TAG_PRIVATE_63) && (w_fin_len == '1)) begin
                    w_fail      = 1'b1;
                    w_fail_code = pgp_pkg::ST_INVALID;
                end else if (CW'(w_fin_len) > w_remain) begin
                    w_fail      = 1'b1;
                    w_fail_code = pgp_pkg::ST_INVALID;
                end else begin
                    w_ok        = 1'b1;
                    n_body_left = w_fin_len;
                    n_state     = (w_fin_len == '0) ? pgp_pkg::S_TAG : pgp_pkg::S_BODY;
                end
            end

            if (w_fail) begin
                n_state = pgp_pkg::S_HALT;
            end
        end
    end

    // Assemble the packet record.
    always_comb begin
        w_res_valid = w_fail || w_ok;
        w_res.packet_type  = n_tag;
        w_res.status       = w_fail_code;
        w_res.body_offset  = '0;
        w_res.body_length  = '0;
        w_res.total_length = '0;
        w_res.last_packet  = 1'b0;
        if (w_ok) begin
            w_res.body_offset  = w_off[31:0];
            w_res.body_length  = w_fin_len;
            w_res.total_length = w_fin_len + 32'(w_hdr_size);
            w_res.last_packet  = (w_remain == CW'(w_fin_len));
        end
    end

    // The output register is loaded on a result and emptied when taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_pop && w_res_valid) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Configuration and parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_length <= '0;
            r_state        <= pgp_pkg::S_TAG;
            r_pos          <= '0;
            r_hdr_start    <= '0;
            r_acc          <= '0;
            r_left         <= '0;
            r_tag          <= '0;
            r_new_fmt      <= 1'b0;
            r_body_left    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_image_length <= i_cfg_wr_data;
            end
            if (o_pop) begin
                r_state     <= n_state;
                r_pos       <= n_pos;
                r_hdr_start <= n_hdr_start;
                r_acc       <= n_acc;
                r_left      <= n_left;
                r_tag       <= n_tag;
                r_new_fmt   <= n_new_fmt;
                r_body_left <= n_body_left;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `PGP_ASSERT_NXT(a_halt_sticky, i_clk, i_rst_n, (r_state == pgp_pkg::S_HALT) && !(o_pop && i_info.restart), r_state == pgp_pkg::S_HALT)
    `PGP_ASSERT_IMP(a_no_result_halted, i_clk, i_rst_n, o_pop && w_res_valid, w_cur_state != pgp_pkg::S_HALT)
    `PGP_ASSERT_NXT(a_ok_enters_body, i_clk, i_rst_n, o_pop && w_ok && (w_fin_len != '0), r_state == pgp_pkg::S_BODY)
    `PGP_ASSERT_IMP(a_one_outcome, i_clk, i_rst_n, w_active, !(w_fail && w_ok))

endmodule

`default_nettype wire

>>> src/pgp_packet_header_parser_core.sv
// Top level of the OpenPGP packet header parser.
//
// The block scans a keyblock image one byte per transaction and sustains one
// byte per clock unless the output stalls: the parser state machine retires one
// queued byte each cycle, and a result enters the output register as the parser
// pops the byte that ends a header. A four-entry queue sits between the byte
// classifier and the parser; while a record waits in a stalled output register
// the parser stops, and the input takes up to four more bytes before it stalls
// too. Each packet yields one record when its last header byte arrives; body
// bytes produce nothing. An error record halts the parser until a byte marked
// restart. Write image_length before the first byte of an image.
`default_nettype none

module pgp_packet_header_parser_core #(
    parameter int POS_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_restart,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [5:0]       o_packet_type,
    output logic [31:0]      o_body_offset,
    output logic [31:0]      o_body_length,
    output logic [31:0]      o_total_length,
    output logic [1:0]       o_status,
    output logic             o_last_packet
);

    pgp_pkg::t_byte_info w_push_info;
    pgp_pkg::t_byte_info w_pop_info;
    pgp_pkg::t_result    w_result;
    logic                w_push;
    logic                w_pop;
    logic                w_full;
    logic                w_empty;

    // Byte classification and input handshake.
    pgp_front u_front (
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_restart   (i_restart),
        .i_full      (w_full),
        .o_stall     (o_stall),
        .o_push      (w_push),
        .o_info      (w_push_info)
    );

    // Queue between the front end and the parser.
    pgp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_info  (w_push_info),
        .i_pop   (w_pop),
        .o_info  (w_pop_info),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Header parser and output register.
    pgp_back #(
        .POS_BITS (POS_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_info        (w_pop_info),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_result      (w_result)
    );

    assign o_packet_type  = w_result.packet_type;
    assign o_body_offset  = w_result.body_offset;
    assign o_body_length  = w_result.body_length;
    assign o_total_length = w_result.total_length;
    assign o_status       = w_result.status;
    assign o_last_packet  = w_result.last_packet;

endmodule

`default_nettype wire

>>> bench/pgp_packet_header_parser_core_test.sv
// Self-checking bench for the packet header parser: a directed table, then random keyblock images.
`timescale 1ns / 1ps

module pgp_packet_header_parser_core_test;

    // Tags a keyblock may carry, one bit per tag number.
    localparam logic [63:0] KEYBLOCK_TAGS   = 64'hA000_0000_0003_74E4;
    localparam logic [63:0] POS_MAX         = 64'hFFFF_FFFF;
    localparam int unsigned SETTLE_CYCLES   = 2 * pgp_pkg::FIFO_DEPTH + 8;
    localparam int unsigned HOLD_OFF_CYCLES = 80;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned RANDOM_BYTES    = 370;

    // One row of the directed table: a register write, or a byte with an optional typed record.
    typedef struct packed {
        logic             is_cfg;
        logic [31:0]      cfg_val;
        logic [7:0]       b;
        logic             rs;
        logic             fixed;
        logic             fixed_hit;
        pgp_pkg::t_result fixed_rec;
    } t_dir_row;

    typedef struct packed {
        logic [7:0] b;
        logic       rs;
    } t_image_byte;

    localparam pgp_pkg::t_result NO_REC = '0;

    localparam t_dir_row DIRECTED_ROWS [30] = '{
        '{0, 0, 8'hC2, 1, 1, 0, NO_REC},
        '{1, 32'hFFFF_FFFF, 0, 0, 0, 0, NO_REC},
        '{0, 0, 8'hFF, 1, 0, 0, NO_REC},
        '{0, 0, 8'hFF, 0, 0, 0, NO_REC},
        '{0, 0, 8'hFF, 0, 0, 0, NO_REC},
        '{0, 0, 8'hFF, 0, 0, 0, NO_REC},
        '{0, 0, 8'hFF, 0, 0, 0, NO_REC},
        '{0, 0, 8'hFF, 0, 1, 1, '{63, 0, 0, 0, pgp_pkg::ST_INVALID, 0}},
        '{0, 0, 8'h3F, 1, 1, 1, '{0, 0, 0, 0, pgp_pkg::ST_INVALID, 0}},
        '{0, 0, 8'hC8, 1, 0, 0, NO_REC},
        '{0, 0, 8'h05, 0, 1, 1, '{8, 0, 0, 0, pgp_pkg::ST_UNEXPECTED, 0}},
        '{0, 0, 8'hC2, 1, 0, 0, NO_REC},
        '{0, 0, 8'hE0, 0, 1, 1, '{2, 0, 0, 0, pgp_pkg::ST_UNEXPECTED, 0}},
        '{0, 0, 8'h8F, 1, 1, 1, '{3, 0, 0, 0, pgp_pkg::ST_UNEXPECTED, 0}},
        '{0, 0, 8'hC4, 1, 0, 0, NO_REC},
        '{0, 0, 8'h00, 0, 1, 1, '{4, 0, 0, 0, pgp_pkg::ST_UNEXPECTED, 0}},
        '{1, 2, 0, 0, 0, 0, NO_REC},
        '{0, 0, 8'h86, 1, 1, 1, '{1, 0, 0, 0, pgp_pkg::ST_INVALID, 0}},
        '{0, 0, 8'hC2, 1, 0, 0, NO_REC},
        '{0, 0, 8'hC0, 0, 1, 1, '{2, 0, 0, 0, pgp_pkg::ST_INVALID, 0}},
        '{0, 0, 8'hB4, 1, 0, 0, NO_REC},
        '{0, 0, 8'h00, 0, 1, 1, '{13, 2, 0, 2, pgp_pkg::ST_OK, 1}},
        '{0, 0, 8'hB4, 1, 0, 0, NO_REC},
        '{0, 0, 8'h01, 0, 1, 1, '{13, 0, 0, 0, pgp_pkg::ST_INVALID, 0}},
        '{1, 3, 0, 0, 0, 0, NO_REC},
        '{0, 0, 8'hD1, 1, 0, 0, NO_REC},
        '{0, 0, 8'h00, 0, 0, 0, NO_REC},
        '{0, 0, 8'hD1, 0, 1, 1, '{17, 0, 0, 0, pgp_pkg::ST_INVALID, 0}},
        '{0, 0, 8'hCD, 1, 0, 0, NO_REC},
        '{0, 0, 8'hFF, 0, 1, 1, '{13, 0, 0, 0, pgp_pkg::ST_INVALID, 0}}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_data_byte   = '0;
    logic        i_restart     = 1'b0;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [5:0]  o_packet_type;
    logic [31:0] o_body_offset;
    logic [31:0] o_body_length;
    logic [31:0] o_total_length;
    logic [1:0]  o_status;
    logic        o_last_packet;

    // Header model state and its copy of the register.
    logic [31:0]      img_len;
    pgp_pkg::t_state  parse_phase;
    logic [63:0]      pos;
    logic [63:0]      hdr_start;
    logic [31:0]      len_acc;
    logic [2:0]       len_left;
    logic [5:0]       cur_tag;
    logic             new_fmt;
    logic [31:0]      body_left;

    pgp_pkg::t_result expected_records [$];
    t_image_byte      image_bytes [$];
    pgp_pkg::t_result want;

    bit          hold_req = 1'b0;
    int unsigned calm_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned error_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned live_bytes = 0;
    int unsigned records_seen = 0;
    int unsigned last_seen = 0;
    int unsigned cfg_writes = 0;
    int unsigned status_seen [4] = '{0, 0, 0, 0};

    pgp_packet_header_parser_core #(
        .POS_BITS(32)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_restart     (i_restart),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_packet_type (o_packet_type),
        .o_body_offset (o_body_offset),
        .o_body_length (o_body_length),
        .o_total_length(o_total_length),
        .o_status      (o_status),
        .o_last_packet (o_last_packet)
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Header model.
    function automatic void clear_parser();
        parse_phase = pgp_pkg::S_TAG;
        pos         = '0;
        hdr_start   = '0;
        len_acc     = '0;
        len_left    = '0;
        cur_tag     = '0;
        new_fmt     = 1'b0;
        body_left   = '0;
    endfunction

    // An error record carries only the tag seen so far and halts the parser.
    function automatic pgp_pkg::t_result fault_record(input logic [1:0] st);
        pgp_pkg::t_result rec;
        rec             = '0;
        rec.packet_type = cur_tag;
        rec.status      = st;
        parse_phase     = pgp_pkg::S_HALT;
        return rec;
    endfunction

    // The header ends at offset p with r image bytes after it.
    function automatic pgp_pkg::t_result close_header(input logic [31:0] len,
                                                      input logic [63:0] p,
                                                      input logic [63:0] r);
        pgp_pkg::t_result rec;
        logic [63:0]      off;
        logic [63:0]      tot;
        off      = p + 1;
        len_acc  = len;
        len_left = '0;
        if (!KEYBLOCK_TAGS[cur_tag]) return fault_record(pgp_pkg::ST_UNEXPECTED);
        if (cur_tag == pgp_pkg::TAG_PRIVATE_63 && len == 32'hFFFF_FFFF)
            return fault_record(pgp_pkg::ST_INVALID);
        if ({32'd0, len} > r) return fault_record(pgp_pkg::ST_INVALID);
        tot              = off - hdr_start + {32'd0, len};
        rec.packet_type  = cur_tag;
        rec.body_offset  = off[31:0];
        rec.body_length  = len;
        rec.total_length = tot[31:0];
        rec.status       = pgp_pkg::ST_OK;
        rec.last_packet  = (r == {32'd0, len});
        if (len == 0) begin
            parse_phase = pgp_pkg::S_TAG;
        end else begin
            body_left   = len;
            parse_phase = pgp_pkg::S_BODY;
        end
        return rec;
    endfunction

    // Advances the model by one byte; returns 1 when the byte yields a record.
    function automatic bit parse_byte(input logic [7:0] b, input logic rs,
                                      output pgp_pkg::t_result rec, output bit live);
        logic [63:0] p;
        logic [63:0] r;
        int unsigned n;
        rec  = '0;
        live = 1'b0;
        if (rs) clear_parser();
        if (parse_phase == pgp_pkg::S_HALT) return 1'b0;
        p = pos;
        if (p >= {32'd0, img_len}) return 1'b0;
        live = 1'b1;
        r    = {32'd0, img_len} - p - 1;
        pos  = (p >= POS_MAX) ? POS_MAX : p + 1;
        case (parse_phase)
            pgp_pkg::S_TAG: begin
                hdr_start = p;
                len_acc   = '0;
                cur_tag   = '0;
                if (!b[7]) begin
                    rec = fault_record(pgp_pkg::ST_INVALID);
                    return 1'b1;
                end
                if (b[6]) begin
                    new_fmt  = 1'b1;
                    cur_tag  = b[5:0];
                    len_left = '0;
                    if (r == 0) begin
                        rec = fault_record(pgp_pkg::ST_INVALID);
                        return 1'b1;
                    end
                end else begin
                    new_fmt = 1'b0;
                    cur_tag = {2'b00, b[5:2]};
                    if (b[1:0] == 2'd3) begin
                        rec = fault_record(pgp_pkg::ST_UNEXPECTED);
                        return 1'b1;
                    end
                    n = 1 << b[1:0];
                    if (r < n) begin
                        rec = fault_record(pgp_pkg::ST_INVALID);
                        return 1'b1;
                    end
                    len_left = 3'(n);
                end
                parse_phase = pgp_pkg::S_LEN;
                return 1'b0;
            end
            pgp_pkg::S_LEN: begin
                // First length byte of a new-format header selects the length form.
                if (new_fmt && len_left == 0) begin
                    if (cur_tag == pgp_pkg::TAG_COMPRESSED) begin
                        rec = fault_record(pgp_pkg::ST_UNEXPECTED);
                        return 1'b1;
                    end
                    if (b < 192) begin
                        rec = close_header({24'd0, b}, p, r);
                        return 1'b1;
                    end
                    if (b < 224) begin
                        if (r == 0) begin
                            rec = fault_record(pgp_pkg::ST_INVALID);
                            return 1'b1;
                        end
                        len_acc  = (b - 192) * 256 + 192;
                        len_left = 3'd1;
                        return 1'b0;
                    end
                    if (b == 8'hFF) begin
                        if (r < 4) begin
                            rec = fault_record(pgp_pkg::ST_INVALID);
                            return 1'b1;
                        end
                        len_acc  = '0;
                        len_left = 3'd4;
                        return 1'b0;
                    end
                    rec = fault_record(pgp_pkg::ST_UNEXPECTED);
                    return 1'b1;
                end
                // Multi-byte lengths are big endian; the sum is kept shifted.
                if (len_left > 1) begin
                    len_acc  = (len_acc + b) << 8;
                    len_left = len_left - 1;
                    return 1'b0;
                end
                rec = close_header(len_acc + b, p, r);
                return 1'b1;
            end
            pgp_pkg::S_BODY: begin
                if (body_left > 1) begin
                    body_left = body_left - 1;
                end else begin
                    body_left   = '0;
                    parse_phase = pgp_pkg::S_TAG;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Short gaps mostly, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp);
        if (got !== exp)
            report_mismatch($sformatf("record %0d %s: got 0x%0h, expected 0x%0h",
                                      records_seen, name, got, exp));
    endtask

    // Offers one byte, waits for the transaction, and queues the record it should yield.
    task automatic stream_byte(input logic [7:0] b, input logic rs, input bit fixed,
                               input bit fixed_hit, input pgp_pkg::t_result fixed_rec);
        int unsigned      gap;
        bit               hit;
        bit               live;
        pgp_pkg::t_result rec;
        if (calm_left > 0) begin
            calm_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 99) < 5) calm_left = $urandom_range(20, 60);
            gap = pick_gap();
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_restart   <= rs;
        do @(posedge i_clk); while (o_stall);
        hit = parse_byte(b, rs, rec, live);
        bytes_sent++;
        if (live) live_bytes++;
        if (fixed) begin
            hit = fixed_hit;
            rec = fixed_rec;
        end
        if (hit) begin
            expected_records.push_back(rec);
        end
    endtask

    // The register is written only once the parser has drained.
    task automatic load_image_length(input logic [31:0] value);
        i_valid <= 1'b0;
        while (expected_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        img_len = value;
        cfg_writes++;
    endtask

    // Builds one image: well-formed packets with random content, some noise, some overruns.
    task automatic build_image(input int unsigned span);
        int unsigned left;
        int unsigned nlen;
        int unsigned blen;
        int unsigned k;
        int unsigned pick;
        int          i;
        logic [1:0]  form;
        logic [5:0]  tg;
        bit          newf;
        logic [7:0]  hdr [$];
        image_bytes.delete();
        left = span;
        while (left > 0) begin
            hdr.delete();
            blen = 0;
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                // A stray byte, an old tag of indeterminate length, or a partial length.
                case (pick % 3)
                    0: hdr.push_back(8'($urandom));
                    1: hdr.push_back(8'h83 | (8'($urandom_range(0, 15)) << 2));
                    default: begin
                        hdr.push_back(8'hC0 | 8'($urandom_range(0, 63)));
                        hdr.push_back(8'($urandom_range(224, 254)));
                    end
                endcase
            end else begin
                if (pick < 90) begin
                    do tg = 6'($urandom_range(0, 63)); while (!KEYBLOCK_TAGS[tg]);
                end else begin
                    tg = 6'($urandom_range(0, 63));
                end
                newf = (tg > 15) || ($urandom_range(0, 1) == 1);
                form = 2'($urandom_range(0, 2));
                if (newf && form == 2'd1 && $urandom_range(0, 9) != 0) form = 2'd0;
                nlen = (form == 2'd0) ? 1 : (form == 2'd1) ? 2 : (newf ? 5 : 4);
                // Mostly short bodies, some that end the image exactly, a few far too long.
                k = $urandom_range(0, 99);
                if (k < 5)
                    blen = $urandom;
                else if (k < 40 && left > nlen + 1 && left - nlen - 1 <= 40)
                    blen = left - nlen - 1;
                else
                    blen = $urandom_range(0, 12);
                if (newf) begin
                    if (form == 2'd0) blen = blen % 192;
                    if (form == 2'd1) blen = 192 + blen % 9;
                    hdr.push_back(8'hC0 | 8'(tg));
                    if (form == 2'd0) begin
                        hdr.push_back(8'(blen));
                    end else if (form == 2'd1) begin
                        hdr.push_back(8'((blen - 192) >> 8) + 8'd192);
                        hdr.push_back(8'(blen - 192));
                    end else begin
                        hdr.push_back(8'hFF);
                        for (i = 3; i >= 0; i--) hdr.push_back(8'(blen >> (8 * i)));
                    end
                end else begin
                    if (nlen == 1) blen = blen & 32'hFF;
                    if (nlen == 2) blen = blen & 32'hFFFF;
                    hdr.push_back(8'h80 | (8'(tg[3:0]) << 2) | 8'(form));
                    for (i = int'(nlen) - 1; i >= 0; i--) hdr.push_back(8'(blen >> (8 * i)));
                end
            end
            foreach (hdr[j]) begin
                if (left > 0) begin
                    image_bytes.push_back(t_image_byte'{hdr[j], (image_bytes.size() == 0)});
                    left--;
                end
            end
            for (k = 0; k < blen && left > 0; k++) begin
                image_bytes.push_back(t_image_byte'{8'($urandom), 1'b0});
                left--;
            end
        end
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off on request.
    initial begin : receiver
        int unsigned n_stall;
        int unsigned n_run;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                n_stall  = HOLD_OFF_CYCLES;
            end else begin
                n_stall = pick_gap();
            end
            n_run = ($urandom_range(0, 99) < 20) ? $urandom_range(20, 60) : $urandom_range(1, 5);
            if (n_stall > 0) begin
                i_stall <= 1'b1;
                repeat (n_stall) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat (n_run) @(posedge i_clk);
        end
    end

    // Each accepted output transaction is checked against the oldest expected record.
    always @(posedge i_clk) begin
        if (o_valid === 1'b1 && i_stall == 1'b0) begin
            records_seen++;
            status_seen[o_status]++;
            if (o_last_packet) last_seen++;
            if (expected_records.size() == 0) begin
                report_mismatch($sformatf("record %0d arrived with none expected",
                                          records_seen));
            end else begin
                want = expected_records.pop_front();
                check_field("packet_type", 32'(o_packet_type), 32'(want.packet_type));
                check_field("body_offset", o_body_offset, want.body_offset);
                check_field("body_length", o_body_length, want.body_length);
                check_field("total_length", o_total_length, want.total_length);
                check_field("status", 32'(o_status), 32'(want.status));
                check_field("last_packet", 32'(o_last_packet), 32'(want.last_packet));
            end
        end
    end

    // Watchdog: ends the run when no transaction happens for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d records outstanding",
                     WATCHDOG_LIMIT, expected_records.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus: reset, the directed table, then random images under changing image lengths.
    initial begin : stimulus
        int unsigned cfg;
        int unsigned span;
        int unsigned n_img;
        int unsigned img;
        int unsigned k;
        int unsigned base_sent;
        t_dir_row    row;
        clear_parser();
        img_len = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[n]) begin
            row = DIRECTED_ROWS[n];
            if (row.is_cfg)
                load_image_length(row.cfg_val);
            else
                stream_byte(row.b, row.rs, row.fixed, row.fixed_hit, row.fixed_rec);
        end

        hold_req  = 1'b1;
        base_sent = bytes_sent;
        while (bytes_sent - base_sent < RANDOM_BYTES) begin
            k = $urandom_range(0, 99);
            if (k < 70)      cfg = $urandom_range(6, 60);
            else if (k < 80) cfg = 32'hFFFF_FFFF;
            else if (k < 90) cfg = $urandom;
            else             cfg = $urandom_range(0, 3);
            load_image_length(cfg);
            n_img = $urandom_range(2, 6);
            for (img = 0; img < n_img && bytes_sent - base_sent < RANDOM_BYTES; img++) begin
                // Most images match the register; some run past it or are cut short.
                if (cfg > 60) begin
                    span = $urandom_range(10, 60);
                end else begin
                    k = $urandom_range(0, 99);
                    if (k < 75)      span = cfg;
                    else if (k < 90) span = cfg + $urandom_range(1, 5);
                    else             span = $urandom_range(1, (cfg > 0) ? cfg : 1);
                end
                if (span == 0) span = 1;
                build_image(span);
                foreach (image_bytes[j])
                    stream_byte(image_bytes[j].b, image_bytes[j].rs, 1'b0, 1'b0, NO_REC);
            end
        end

        i_valid <= 1'b0;
        while (expected_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d bytes (%0d parsed) under %0d image_length settings.",
                 bytes_sent, live_bytes, cfg_writes);
        $display("Checked %0d records: %0d ok, %0d invalid, %0d unexpected, %0d last; %0d errors.",
                 records_seen, status_seen[pgp_pkg::ST_OK], status_seen[pgp_pkg::ST_INVALID],
                 status_seen[pgp_pkg::ST_UNEXPECTED], last_seen, error_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> pgp_packet_header_parser_core.f
+incdir+src
src/pgp_pkg.sv
src/pgp_front.sv
src/pgp_fifo.sv
src/pgp_back.sv
src/pgp_packet_header_parser_core.sv
bench/pgp_packet_header_parser_core_test.sv
